/* src/assert_macros.svh */
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/ptt_pkg.sv */
`default_nettype none

package ptt_pkg;

	// Counter and field widths.
	localparam int CNT_W  = 16;
	localparam int USEC_W = 20;
	localparam int TS_W   = 64;
	localparam int OFFS_W = 32;

	// Shared divider: the dividend is wide enough for a counter span times
	// the microsecond period.
	localparam int DVD_W     = CNT_W + USEC_W;
	localparam int DVS_W     = CNT_W;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	// Stream widths.
	localparam int IN_DATA_W  = 2 * CNT_W;
	localparam int OUT_FLD_W  = 3 * CNT_W + 2 + TS_W + OFFS_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = USEC_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICKS_PER_JIFFY  = 2'd0,
		CFG_USEC_PER_JIFFY   = 2'd1,
		CFG_TIMER_STOLEN     = 2'd2,
		CFG_TIMESTAMP_ENABLE = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		REQ_TICK      = 3'd0,
		REQ_ACK       = 3'd1,
		REQ_READ_TS   = 3'd2,
		REQ_DEADLINE  = 3'd3,
		REQ_REMAINING = 3'd4,
		REQ_OFFSET    = 3'd5
	} req_t;

	localparam logic [CNT_W-1:0]  TICKS_RESET    = 16'd18750;
	localparam logic [USEC_W-1:0] USEC_RESET     = 20'd10000;
	localparam logic [CNT_W-1:0]  SHORT_DEADLINE = 16'd2;
	localparam logic [OFFS_W-1:0] OFFS_MAX       = '1;

endpackage

`default_nettype wire

/* src/ptt_div.sv */
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module ptt_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ptt_pkg::DVD_W-1:0]  dividend,
	input  wire logic [ptt_pkg::DVS_W-1:0]  divisor,
	output logic                            done,
	output logic [ptt_pkg::DVD_W-1:0]       quotient,
	output logic [ptt_pkg::DVS_W-1:0]       remainder
);
	import ptt_pkg::*;

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEP_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - STEP_W'(1);
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* src/periodic_tick_tracker_with_timestamp.sv */
// Flow: a normal tick or an offset read with a nonzero period passes through the multiplier
// and the 36-step shared divider; every other request goes straight to the finish state.
// One item is taken at a time: the input is ready again only after the finish state hands
// its result to the output register, which waits while an output stall holds it full.
// Reset: arst_n is asynchronous and active low; it restores the configuration defaults,
// clears the boundary and timestamp, and loads the compare register with the default period.
`default_nettype none

module periodic_tick_tracker_with_timestamp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Input items.
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [ptt_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // counter_value, delay
	input  wire logic [2:0]                         s_axis_tuser,  // req_type
	// Result items.
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// ticks_elapsed, compare_out, compare_written, trigger_now, timestamp,
	// remaining, offset_usec, then zero padding.
	output logic [ptt_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// Configuration writes.
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ptt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ptt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ptt_pkg::*;

	// The sequencer walks one item through the multiplier and the shared divider.
	// Requests that need no division go straight to the finish state.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CNT_W-1:0]  period_q;
	logic [USEC_W-1:0] usec_q;
	logic              stolen_q;
	logic              ts_en_q;

	// Tracker state.
	logic [CNT_W-1:0] boundary_q;
	logic [CNT_W-1:0] compare_q;
	logic [TS_W-1:0]  ext_q;

	// The item being worked on.
	req_t             req_q;
	logic [CNT_W-1:0] cv_q;
	logic [CNT_W-1:0] delay_q;

	// Output register.
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic             in_accept;
	logic             out_free;
	req_t             in_req;
	logic             in_needs_div;
	logic [CNT_W-1:0] elapsed;

	logic             div_start;
	logic [DVD_W-1:0] div_dividend;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;

	// Values computed in the finish state.
	logic [CNT_W-1:0]  f_ticks;
	logic [CNT_W-1:0]  f_compare;
	logic              f_written;
	logic              f_trig;
	logic [TS_W-1:0]   f_ts;
	logic [CNT_W-1:0]  f_rem;
	logic [OFFS_W-1:0] f_offs;
	logic [CNT_W-1:0]  f_boundary;
	logic [TS_W-1:0]   f_ext;
	logic [TS_W-1:0]   ext_sample;
	logic [CNT_W-1:0]  new_boundary;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign in_req        = req_t'(s_axis_tuser);

	// A division runs for a normal tick and for an offset read, and only when the
	// period is nonzero.
	assign in_needs_div = (period_q != '0) &&
		((in_req == REQ_TICK && !stolen_q) || in_req == REQ_OFFSET);

	assign elapsed = cv_q - boundary_q;

	// The product (for a tick, the elapsed count) is loaded straight into the divider's dividend register.
	assign div_start    = (state_q == ST_MUL);
	assign div_dividend = (req_q == REQ_OFFSET) ? DVD_W'(elapsed) * DVD_W'(usec_q)
	                                            : DVD_W'(elapsed);

	ptt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (period_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Wrap extension: if the sample is below the stored low bits, the counter wrapped.
	assign ext_sample = {ext_q[TS_W-1:CNT_W] + (TS_W-CNT_W)'(cv_q < ext_q[CNT_W-1:0]), cv_q};

	// The boundary after a normal tick with a nonzero period sits the remainder of the division
	// below the sample, which saves multiplying the quotient back by the period.
	assign new_boundary = (period_q == '0) ? boundary_q : cv_q - div_rem;

	always_comb begin
		f_ticks    = '0;
		f_compare  = compare_q;
		f_written  = 1'b0;
		f_trig     = 1'b0;
		f_ts       = '0;
		f_rem      = '0;
		f_offs     = '0;
		f_boundary = boundary_q;
		f_ext      = ext_q;
		case (req_q)
			REQ_TICK: begin
				if (stolen_q) begin
					f_ticks    = CNT_W'(1);
					f_boundary = boundary_q + period_q;
				end else begin
					f_ticks    = (period_q == '0) ? '0 : div_quo[CNT_W-1:0];
					f_boundary = new_boundary;
					f_compare  = new_boundary + period_q;
					f_written  = 1'b1;
				end
			end
			REQ_ACK: begin
				if (ts_en_q) begin
					f_ext = ext_sample;
					f_ts  = ext_sample;
				end
			end
			REQ_READ_TS: begin
				if (ts_en_q) begin
					f_ts = ext_sample;
				end
			end
			REQ_DEADLINE: begin
				if (delay_q > SHORT_DEADLINE) begin
					f_compare = cv_q + delay_q;
					f_written = 1'b1;
				end else begin
					f_trig = 1'b1;
				end
			end
			REQ_REMAINING: begin
				f_rem = compare_q - cv_q;
			end
			REQ_OFFSET: begin
				// A zero period and a quotient beyond 32 bits both saturate.
				if (period_q == '0 || div_quo[DVD_W-1:OFFS_W] != '0) begin
					f_offs = OFFS_MAX;
				end else begin
					f_offs = div_quo[OFFS_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, configuration and tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			period_q   <= TICKS_RESET;
			usec_q     <= USEC_RESET;
			stolen_q   <= 1'b0;
			ts_en_q    <= 1'b0;
			boundary_q <= '0;
			compare_q  <= TICKS_RESET;
			ext_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TICKS_PER_JIFFY:  period_q <= cfg_data[CNT_W-1:0];
					CFG_USEC_PER_JIFFY:   usec_q   <= cfg_data;
					CFG_TIMER_STOLEN:     stolen_q <= cfg_data[0];
					CFG_TIMESTAMP_ENABLE: ts_en_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end

			// A new result takes the output register as soon as it is free.
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= in_needs_div ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						boundary_q <= f_boundary;
						compare_q  <= f_compare;
						ext_q      <= f_ext;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q   <= in_req;
			cv_q    <= s_axis_tdata[CNT_W-1:0];
			delay_q <= s_axis_tdata[2*CNT_W-1:CNT_W];
		end
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= {{OUT_PAD_W{1'b0}}, f_offs, f_rem, f_ts, f_trig, f_written,
				f_compare, f_ticks};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

/* src/ptt_chk.sv */
`default_nettype none
`include "assert_macros.svh"

module ptt_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [ptt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import ptt_pkg::*;

	logic written;
	logic trig;

	assign written = m_axis_tdata[2*CNT_W];
	assign trig    = m_axis_tdata[2*CNT_W+1];

	// After an item is accepted, the input is not ready in the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// A stalled result stays put.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// A short deadline triggers and never also writes the compare register; no result has both flags.
	`ASSERT_ALWAYS(a_trig_excl, clk, arst_n, !m_axis_tvalid || !(written && trig))

endmodule

bind periodic_tick_tracker_with_timestamp ptt_chk u_ptt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
